// ===== design/ayuv420_pkg.sv =====
// Shared types, constants and helpers for the packed 4:4:4 to planar 4:2:0 converter.
// No dependencies; every other file in the design imports this package.
package ayuv420_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int SIZE_W     = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int OFFSET_W   = 24;
    localparam int CBASE_W    = $clog2(LINE_DEPTH * (MAX_HEIGHT / 2));
    localparam int CFG_IDX_W  = 2;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_PW + 1;
    localparam int MAX_PUSH   = 3;

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PLANE_Y  = 2'd0,
        PLANE_CB = 2'd1,
        PLANE_CR = 2'd2
    } t_plane;

    typedef struct packed {
        t_plane                plane;
        logic [OFFSET_W-1:0]   offset;
        logic [7:0]            sample;
        logic                  last_of_pixel;
        logic                  frame_end;
    } t_result;

    // Clamp a requested frame dimension to 2..maxv and force it even.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] c;
        c = v;
        if (c < SIZE_W'(2)) c = SIZE_W'(2);
        if (c > maxv)       c = maxv;
        return {c[SIZE_W-1:1], 1'b0};
    endfunction

    // Chroma quarter with round-half-up: (x + 2) >> 2, range 0..64.
    function automatic logic [6:0] quarter(input logic [7:0] x);
        logic [8:0] s;
        s = {1'b0, x} + 9'd2;
        return s[8:2];
    endfunction

endpackage

// ===== design/ayuv_to_planar_420_converter_unit.sv =====
// Top level of the packed 4:4:4 to planar 4:2:0 converter.
// Uses ayuv420_pkg, ayuv420_pixel_pipe and ayuv420_result_fifo.

// Takes one packed Y/Cb/Cr pixel per beat in raster order and emits a luma
// result for every pixel, plus a Cb and a Cr result on each odd-row, odd-column
// pixel, each tagged with its plane and byte offset. A pixel is taken every
// clock on even rows while the output is not stalled; on odd rows every second
// pixel produces three results, so the single output beat per clock limits the
// input rate there. Results pass through the stage-1 registers and then an
// eight-entry result queue. Writing frame_width or frame_height restarts the
// frame at the top-left pixel; sizes are clamped to 2..4096 and forced even. The
// line store needs no clearing pass: each entry is written on an even row
// before the following odd row reads it.
module ayuv_to_planar_420_converter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ayuv420_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ayuv420_pkg::SIZE_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_luma,
    input  logic [7:0]                         i_blue_diff,
    input  logic [7:0]                         i_red_diff,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_plane,
    output logic [23:0]                        o_offset,
    output logic [7:0]                         o_sample,
    output logic                               o_last_of_pixel,
    output logic                               o_frame_end
);
    import ayuv420_pkg::*;

    logic               accept;
    logic [1:0]         pending_n;
    logic [1:0]         push_n;
    t_result            push [MAX_PUSH];
    t_result            head;
    logic [FIFO_CW-1:0] count;
    logic [FIFO_CW:0]   committed;

    // Room must remain for the beat in flight plus a full three-result pixel.
    assign committed = {1'b0, count} + (FIFO_CW + 1)'(pending_n);
    assign o_stall   = committed > (FIFO_CW + 1)'(FIFO_DEPTH - MAX_PUSH);
    assign accept    = i_valid && !o_stall;

    ayuv420_pixel_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_luma      (i_luma),
        .i_blue_diff (i_blue_diff),
        .i_red_diff  (i_red_diff),
        .o_pending_n (pending_n),
        .o_push_n    (push_n),
        .o_push      (push)
    );

    ayuv420_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_push   (push),
        .i_pop    (!i_stall),
        .o_valid  (o_valid),
        .o_head   (head),
        .o_count  (count)
    );

    assign o_plane         = head.plane;
    assign o_offset        = head.offset;
    assign o_sample        = head.sample;
    assign o_last_of_pixel = head.last_of_pixel;
    assign o_frame_end     = head.frame_end;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, count} + (FIFO_CW + 1)'(push_n)) <= (FIFO_CW + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_cr_follows_cb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_plane == PLANE_CB) |=> (o_valid && o_plane == PLANE_CR))
        else $error("Cb result not followed by its Cr result");

    a_frame_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_last_of_pixel)
        else $error("frame end flagged on a result that does not close its pixel");

    a_chroma_closes_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_plane == PLANE_Y && !o_last_of_pixel) |-> (count >= FIFO_CW'(3)))
        else $error("luma of a chroma pixel queued without its chroma results");
`endif

endmodule

// ===== design/ayuv420_line_store.sv =====
// Line store holding the upper row's Cb and Cr pair sums, one entry per column pair.
// Synchronous single-port-write, single-port-read memory; uses ayuv420_pkg.
module ayuv420_line_store (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [ayuv420_pkg::LINE_AW-1:0] i_waddr,
    input  logic [15:0]                    i_wdata,
    input  logic                           i_re,
    input  logic [ayuv420_pkg::LINE_AW-1:0] i_raddr,
    output logic [15:0]                    o_rdata
);
    import ayuv420_pkg::*;

    logic [15:0] r_mem [LINE_DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ayuv420_result_fifo.sv =====
// Result queue that takes up to three results per cycle and hands out one per beat.
// Depends on ayuv420_pkg for the result type and depth.
module ayuv420_result_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [1:0]                      i_push_n,
    input  ayuv420_pkg::t_result            i_push [ayuv420_pkg::MAX_PUSH],
    input  logic                            i_pop,
    output logic                            o_valid,
    output ayuv420_pkg::t_result            o_head,
    output logic [ayuv420_pkg::FIFO_CW-1:0] o_count
);
    import ayuv420_pkg::*;

    t_result             r_buf [FIFO_DEPTH];
    logic [FIFO_PW-1:0]  r_wr;
    logic [FIFO_PW-1:0]  n_wr;
    logic [FIFO_PW-1:0]  r_rd;
    logic [FIFO_PW-1:0]  n_rd;
    logic [FIFO_CW-1:0]  r_count;
    logic [FIFO_CW-1:0]  n_count;
    logic                do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign n_wr    = r_wr + FIFO_PW'(i_push_n);
    assign n_rd    = r_rd + FIFO_PW'(do_pop);
    assign n_count = r_count + FIFO_CW'(i_push_n) - FIFO_CW'(do_pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (2'(k) < i_push_n) begin
                r_buf[r_wr + FIFO_PW'(k)] <= i_push[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_buf[r_rd];
    assign o_count = r_count;

endmodule

// ===== design/ayuv420_pixel_pipe.sv =====
// Two-stage pixel pipeline: raster position, chroma pair sums, line-store
// read-modify-write and result formation. Uses ayuv420_pkg and ayuv420_line_store.
module ayuv420_pixel_pipe (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ayuv420_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ayuv420_pkg::SIZE_W-1:0]     i_cfg_data,
    input  logic                               i_accept,
    input  logic [7:0]                         i_luma,
    input  logic [7:0]                         i_blue_diff,
    input  logic [7:0]                         i_red_diff,
    output logic [1:0]                         o_pending_n,
    output logic [1:0]                         o_push_n,
    output ayuv420_pkg::t_result               o_push [ayuv420_pkg::MAX_PUSH]
);
    import ayuv420_pkg::*;

    // Configuration, held as effective (clamped, even) sizes.
    logic [SIZE_W-1:0]   r_w;
    logic [SIZE_W-1:0]   r_h;
    logic                restart;

    // Position and offset tracking for the next pixel.
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [OFFSET_W-1:0] r_loff;
    logic [CBASE_W-1:0]  r_cbase;
    logic [6:0]          r_pcb;
    logic [6:0]          r_pcr;

    // Stage 1 registers.
    logic                r_v1;
    logic                r_three;
    logic [7:0]          r_y;
    logic [7:0]          r_sb;
    logic [7:0]          r_sr;
    logic [OFFSET_W-1:0] r_loff1;
    logic [OFFSET_W-1:0] r_coff1;
    logic                r_flast;

    logic [6:0]          qb;
    logic [6:0]          qr;
    logic [7:0]          sb;
    logic [7:0]          sr;
    logic                col_odd;
    logic                row_odd;
    logic                col_end;
    logic                row_end;
    logic [LINE_AW-1:0]  idx;
    logic                mem_we;
    logic                mem_re;
    logic [15:0]         mem_rdata;
    logic [8:0]          tb;
    logic [8:0]          tr;
    logic [7:0]          tb_sat;
    logic [7:0]          tr_sat;

    assign restart = i_cfg_we &&
                     (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= RESET_WIDTH;
            r_h <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_w <= eff_size(i_cfg_data, SIZE_W'(MAX_WIDTH));
                REG_FRAME_HEIGHT: r_h <= eff_size(i_cfg_data, SIZE_W'(MAX_HEIGHT));
                default:          ;
            endcase
        end
    end

    assign qb      = quarter(i_blue_diff);
    assign qr      = quarter(i_red_diff);
    assign sb      = {1'b0, r_pcb} + {1'b0, qb};
    assign sr      = {1'b0, r_pcr} + {1'b0, qr};
    assign col_odd = r_col[0];
    assign row_odd = r_row[0];
    assign col_end = ({1'b0, r_col} == r_w - SIZE_W'(1));
    assign row_end = ({1'b0, r_row} == r_h - SIZE_W'(1));
    assign idx     = r_col[COL_W-1:1];
    assign mem_we  = i_accept && col_odd && !row_odd;
    assign mem_re  = i_accept && col_odd && row_odd;

    // The upper row's entry is always written on an earlier beat than the one on
    // which the lower row reads it, so the registered read needs no forwarding.
    ayuv420_line_store u_line_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx),
        .i_wdata ({sr, sb}),
        .i_re    (mem_re),
        .i_raddr (idx),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_col   <= '0;
            r_row   <= '0;
            r_loff  <= '0;
            r_cbase <= '0;
            r_pcb   <= '0;
            r_pcr   <= '0;
        end else if (i_accept) begin
            if (!col_odd) begin
                r_pcb <= qb;
                r_pcr <= qr;
            end
            if (col_end) begin
                r_col <= '0;
                if (row_end) begin
                    r_row   <= '0;
                    r_loff  <= '0;
                    r_cbase <= '0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_loff <= r_loff + OFFSET_W'(1);
                    if (row_odd) begin
                        r_cbase <= r_cbase + CBASE_W'(r_w[SIZE_W-1:1]);
                    end
                end
            end else begin
                r_col  <= r_col + COL_W'(1);
                r_loff <= r_loff + OFFSET_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_three <= col_odd && row_odd;
            r_y     <= i_luma;
            r_sb    <= sb;
            r_sr    <= sr;
            r_loff1 <= r_loff;
            r_coff1 <= OFFSET_W'(r_cbase) + OFFSET_W'(idx);
            r_flast <= col_end && row_end;
        end
    end

    assign tb     = {1'b0, r_sb} + {1'b0, mem_rdata[7:0]};
    assign tr     = {1'b0, r_sr} + {1'b0, mem_rdata[15:8]};
    assign tb_sat = tb[8] ? 8'hFF : tb[7:0];
    assign tr_sat = tr[8] ? 8'hFF : tr[7:0];

    always_comb begin
        o_pending_n = r_v1 ? (r_three ? 2'd3 : 2'd1) : 2'd0;
        o_push_n    = o_pending_n;

        o_push[0].plane         = PLANE_Y;
        o_push[0].offset        = r_loff1;
        o_push[0].sample        = r_y;
        o_push[0].last_of_pixel = !r_three;
        o_push[0].frame_end     = !r_three && r_flast;

        o_push[1].plane         = PLANE_CB;
        o_push[1].offset        = r_coff1;
        o_push[1].sample        = tb_sat;
        o_push[1].last_of_pixel = 1'b0;
        o_push[1].frame_end     = 1'b0;

        o_push[2].plane         = PLANE_CR;
        o_push[2].offset        = r_coff1;
        o_push[2].sample        = tr_sat;
        o_push[2].last_of_pixel = 1'b1;
        o_push[2].frame_end     = r_flast;
    end

endmodule
